/* design/bm3_pkg.sv */
package bm3_pkg;

  // Input opcodes.
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Configuration register indexes.
  localparam int  CFG_INDEX_BITS   = 1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = 1'b1;

  // Configuration data width and frame size limits.
  localparam int CFG_BITS     = 11;
  localparam int FRAME_MIN    = 3;
  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;

  // Per-item control that travels with the pixel column through the window.
  typedef struct packed {
    logic emit0;   // the item produces the pixel left of center
    logic emit1;   // the item also produces the last pixel of the row
    logic border;  // the first result is a border pixel and passes through
    logic eof;     // the second result closes the frame
  } bm3_ctrl_t;

  // Result pushes from the window datapath into the output queue.
  typedef struct packed {
    logic push0;
    logic push1;
    logic eof;
  } bm3_push_t;

endpackage

/* design/bm3_ram.sv */
module bm3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/bm3_window.sv */
module bm3_window
  import bm3_pkg::*;
#(
  parameter int PIXEL_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  clear,
  input  logic                  in_valid,
  input  bm3_ctrl_t             in_ctrl,
  input  logic [PIXEL_BITS-1:0] top_px,
  input  logic [PIXEL_BITS-1:0] mid_px,
  input  logic [PIXEL_BITS-1:0] bot_px,
  output logic [1:0]            busy,
  output bm3_push_t             push,
  output logic [PIXEL_BITS-1:0] val0,
  output logic [PIXEL_BITS-1:0] val1
);

  // Sum of nine pixels and the reciprocal multiply that divides it by nine.
  localparam int SW        = PIXEL_BITS + 4;
  localparam int DIV_SHIFT = SW + 4;
  localparam int RECIP     = ((1 << DIV_SHIFT) + 8) / 9;
  localparam int PW        = SW + DIV_SHIFT;

  logic [PIXEL_BITS-1:0] win [3][3];
  logic                  s2_valid;
  bm3_ctrl_t             s2_ctrl;
  logic [SW-1:0]         sum_next;
  logic                  s3_valid;
  bm3_ctrl_t             s3_ctrl;
  logic [SW-1:0]         s3_sum;
  logic [PIXEL_BITS-1:0] s3_center;
  logic [PIXEL_BITS-1:0] s3_right;
  logic [PW-1:0]         prod;
  logic [PIXEL_BITS-1:0] quot;

  // Window: shift one column left and load the new column on the right.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end else if (in_valid) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= top_px;
      win[1][2] <= mid_px;
      win[2][2] <= bot_px;
    end
  end

  // Stage two control follows the window load.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s2_valid <= in_valid;
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_ctrl <= in_ctrl;
  end

  // Neighborhood sum over the nine window pixels.
  always_comb begin
    sum_next = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        sum_next = sum_next + SW'(win[r][c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    s3_ctrl   <= s2_ctrl;
    s3_sum    <= sum_next;
    s3_center <= win[1][1];
    s3_right  <= win[1][2];
  end

  // Divide by nine: multiply by the rounded-up reciprocal and drop the fraction.
  assign prod = PW'(s3_sum) * PW'(RECIP);
  assign quot = prod[DIV_SHIFT +: PIXEL_BITS];

  assign push.push0 = s3_valid && s3_ctrl.emit0;
  assign push.push1 = s3_valid && s3_ctrl.emit1;
  assign push.eof   = s3_ctrl.eof;
  assign val0       = s3_ctrl.border ? s3_center : quot;
  assign val1       = s3_right;
  assign busy       = {s3_valid, s2_valid};

  // The row's last pixel never comes without the pixel before it.
  a_push_order: assert property (@(posedge clk) disable iff (rst)
    push.push1 |-> push.push0)
    else $error("second result pushed without the first");

  // End of frame only marks a row's closing pixel.
  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    (s3_valid && s3_ctrl.eof) |-> s3_ctrl.emit1)
    else $error("end of frame on an item without a closing pixel");

  // A restart leaves the window center at zero.
  a_clear: assert property (@(posedge clk) disable iff (rst)
    clear |=> (win[1][1] == '0 && win[1][2] == '0))
    else $error("window not cleared on restart");

endmodule

/* design/box_mean_3x3_filter_unit.sv */
// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  opcode, pixel
// out       output     out_valid / out_stall filtered_value, end_of_frame
// cfg       input      cfg_we               cfg_index, cfg_data
//
// One input beat is taken every cycle while the output side keeps up; a beat
// gives its results after the line-store read, window load, sum and divide. The
// output queue sustains one result beat per cycle while out_stall is low; in_stall
// rises only when the queue could not hold the worst case of the beats in flight.
// rst is synchronous; it restores 640 x 480 and restarts the frame. Line
// stores need no clearing pass and keep their contents over reset.
// A configuration write restarts the frame.
module box_mean_3x3_filter_unit
  import bm3_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]       cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      opcode,
  input  logic [PIXEL_BITS-1:0]     pixel,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [PIXEL_BITS-1:0]     filtered_value,
  output logic                      end_of_frame
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RESET_W = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
  localparam int RESET_H = (HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET;
  localparam int FIFO_DEPTH = 16;
  localparam int FA = $clog2(FIFO_DEPTH);
  localparam int FC = $clog2(FIFO_DEPTH + 1);
  localparam int NW = FC + 1;

  logic [CW-1:0]         frame_width;
  logic [HW-1:0]         frame_height;
  logic [XW-1:0]         column_count;
  logic [XW-1:0]         flush_count;
  logic [YW-1:0]         row_count;
  logic                  draining;
  logic [31:0]           cfg_wide;
  logic [31:0]           width_clamp;
  logic [31:0]           height_clamp;
  logic [XW-1:0]         width_last;
  logic [YW-1:0]         height_last;
  logic                  in_acc;
  logic                  eff_pix;
  logic                  eff_flush;
  logic [XW-1:0]         col_sel;
  logic                  col_last;
  logic                  vrow0;
  bm3_ctrl_t             ctrl_next;
  logic                  s1_valid;
  logic                  s1_write;
  logic [XW-1:0]         s1_col;
  logic [PIXEL_BITS-1:0] s1_pix;
  bm3_ctrl_t             s1_ctrl;
  logic [PIXEL_BITS-1:0] older_rd;
  logic [PIXEL_BITS-1:0] newer_rd;
  logic [1:0]            busy;
  bm3_push_t             push;
  logic [PIXEL_BITS-1:0] val0;
  logic [PIXEL_BITS-1:0] val1;
  logic [PIXEL_BITS-1:0] fifo_val [FIFO_DEPTH];
  logic                  fifo_eof [FIFO_DEPTH];
  logic [FA-1:0]         head;
  logic [FA-1:0]         tail;
  logic [FC-1:0]         count;
  logic                  pop;
  logic [NW-1:0]         need;

  // Clamp written frame sizes into the supported range.
  assign cfg_wide     = 32'(cfg_data);
  assign width_clamp  = (cfg_wide < FRAME_MIN) ? 32'(FRAME_MIN) :
                        (cfg_wide > MAX_WIDTH) ? 32'(MAX_WIDTH) : cfg_wide;
  assign height_clamp = (cfg_wide < FRAME_MIN) ? 32'(FRAME_MIN) :
                        (cfg_wide > MAX_HEIGHT) ? 32'(MAX_HEIGHT) : cfg_wide;
  assign width_last   = XW'(frame_width - CW'(1));
  assign height_last  = YW'(frame_height - HW'(1));

  // Decode the accepted beat; mistimed pixels and flush ticks are dropped.
  assign in_acc    = in_valid && !in_stall;
  assign eff_pix   = in_acc && (opcode == OP_PIXEL) && !draining;
  assign eff_flush = in_acc && (opcode == OP_FLUSH) && draining;
  assign col_sel   = draining ? flush_count : column_count;
  assign col_last  = col_sel == width_last;
  assign vrow0     = !draining && (row_count == '0);

  assign ctrl_next.emit0  = !vrow0 && (col_sel != '0);
  assign ctrl_next.emit1  = !vrow0 && col_last;
  assign ctrl_next.border = draining || (row_count == YW'(1)) || (col_sel == XW'(1));
  assign ctrl_next.eof    = draining && col_last;

  // Frame sizes and position counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= CW'(RESET_W);
      frame_height <= HW'(RESET_H);
      column_count <= '0;
      flush_count  <= '0;
      row_count    <= '0;
      draining     <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == REG_FRAME_WIDTH) begin
        frame_width <= CW'(width_clamp);
      end else begin
        frame_height <= HW'(height_clamp);
      end
      column_count <= '0;
      flush_count  <= '0;
      row_count    <= '0;
      draining     <= 1'b0;
    end else if (eff_pix) begin
      if (col_last) begin
        column_count <= '0;
        if (row_count == height_last) begin
          draining    <= 1'b1;
          flush_count <= '0;
        end else begin
          row_count <= row_count + YW'(1);
        end
      end else begin
        column_count <= column_count + XW'(1);
      end
    end else if (eff_flush) begin
      if (col_last) begin
        flush_count <= '0;
        row_count   <= '0;
        draining    <= 1'b0;
      end else begin
        flush_count <= flush_count + XW'(1);
      end
    end
  end

  // Stage one waits for the line-store reads.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= eff_pix || eff_flush;
    end
  end

  always_ff @(posedge clk) begin
    s1_write <= eff_pix;
    s1_col   <= col_sel;
    s1_pix   <= (opcode == OP_PIXEL) ? pixel : '0;
    s1_ctrl  <= ctrl_next;
  end

  // Line stores: the newer row moves down into the older one as pixels arrive.
  bm3_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_older_line (
    .clk   (clk),
    .we    (s1_valid && s1_write),
    .waddr (s1_col),
    .wdata (newer_rd),
    .re    (eff_pix || eff_flush),
    .raddr (col_sel),
    .rdata (older_rd)
  );

  bm3_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_newer_line (
    .clk   (clk),
    .we    (s1_valid && s1_write),
    .waddr (s1_col),
    .wdata (s1_pix),
    .re    (eff_pix || eff_flush),
    .raddr (col_sel),
    .rdata (newer_rd)
  );

  bm3_window #(.PIXEL_BITS(PIXEL_BITS)) u_window (
    .clk      (clk),
    .rst      (rst),
    .clear    (cfg_we),
    .in_valid (s1_valid),
    .in_ctrl  (s1_ctrl),
    .top_px   (older_rd),
    .mid_px   (newer_rd),
    .bot_px   (s1_pix),
    .busy     (busy),
    .push     (push),
    .val0     (val0),
    .val1     (val1)
  );

  // Output queue: up to two pushes and one pop per cycle.
  assign pop = (count != '0) && !out_stall;

  always_ff @(posedge clk) begin
    if (push.push0) begin
      fifo_val[tail] <= val0;
      fifo_eof[tail] <= 1'b0;
    end
    if (push.push1) begin
      fifo_val[tail + FA'(1)] <= val1;
      fifo_eof[tail + FA'(1)] <= push.eof;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail + FA'(push.push0) + FA'(push.push1);
      head  <= head + FA'(pop);
      count <= count + FC'(push.push0) + FC'(push.push1) - FC'(pop);
    end
  end

  // Hold off input unless every beat in flight could still push two results.
  assign need = NW'(count) + NW'({s1_valid, 1'b0}) + NW'({busy[0], 1'b0})
              + NW'({busy[1], 1'b0});
  assign in_stall = need > NW'(FIFO_DEPTH - 2);

  assign out_valid      = count != '0;
  assign filtered_value = fifo_val[head];
  assign end_of_frame   = fifo_eof[head];

  // The queue never overflows.
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FC'(FIFO_DEPTH))
    else $error("output queue overflow");

  // The final flush tick ends draining.
  a_drain_end: assert property (@(posedge clk) disable iff (rst)
    (eff_flush && col_last && !cfg_we) |=> !draining)
    else $error("draining did not end after the final flush beat");

  // The row counter stays inside the frame.
  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    row_count <= height_last)
    else $error("row counter beyond the last row");

  // Draining only starts on the last pixel of the frame.
  a_drain_start: assert property (@(posedge clk) disable iff (rst)
    $rose(draining) |-> $past(eff_pix && col_last))
    else $error("draining started without the frame's last pixel");

endmodule
